/* sv/tcl_pkg.sv */
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types and constants of the text cell layout block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcl_pkg;

    // control characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // configuration register indexes
    localparam logic CFG_COLUMNS   = 1'b0;
    localparam logic CFG_TAB_WIDTH = 1'b1;

    localparam logic [7:0] COLUMNS_RESET   = 8'd80;
    localparam logic [3:0] TAB_WIDTH_RESET = 4'd4;

    // command to the cursor unit for one cycle
    typedef struct packed {
        logic step;      // advance one cell, wrap at the column limit
        logic line_end;  // go to column 0 of the next row
    } t_cur_cmd;

endpackage

`default_nettype wire

/* sv/tcl_cursor.sv */
// ----------------------------------------------------------------------------
// tcl_cursor
// Cursor position registers with one shared single-cell advance unit:
// increment, compare against the column limit, wrap to the next row.
// ----------------------------------------------------------------------------
`default_nettype none

module tcl_cursor #(
    parameter int ROW_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tcl_pkg::t_cur_cmd   i_cmd,
    input  wire logic [7:0]          i_columns,
    output logic      [7:0]          o_column,
    output logic      [ROW_BITS-1:0] o_row
);

    logic [7:0]          r_column, n_column;
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [8:0]          next_col;

    assign next_col = {1'b0, r_column} + 9'd1;

    always_comb begin
        n_column = r_column;
        n_row    = r_row;
        if (i_cmd.line_end || (i_cmd.step && (next_col >= {1'b0, i_columns}))) begin
            n_column = 8'd0;
            n_row    = r_row + {{(ROW_BITS-1){1'b0}}, 1'b1};
        end else if (i_cmd.step) begin
            n_column = next_col[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= 8'd0;
            r_row    <= '0;
        end else begin
            r_column <= n_column;
            r_row    <= n_row;
        end
    end

    assign o_column = r_column;
    assign o_row    = r_row;

endmodule

`default_nettype wire

/* sv/text_cell_layout_top.sv */
// ----------------------------------------------------------------------------
// text_cell_layout_top
// Lays a byte stream of text out on a character-cell grid and emits one
// placement (code, column, row, atlas cell) per byte other than TAB, SP, LF, CR.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_char_code
//  out     | source    | o_out_valid / i_out_stall | o_glyph_code, o_cell_column,
//          |           |                           | o_cell_row, o_atlas_x, o_atlas_y
//  cfg     | sink      | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  A tab moves the cursor tab_width cells, one cell step per cycle through the
//  shared cursor advance unit, and the input stalls while the tab runs.
//  Results sit in an output register; a new beat is taken while the held
//  result drains in the same cycle. Synchronous active-low reset restores
//  columns 80, tab width 4 and a cursor at the origin. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module text_cell_layout_top #(
    parameter int ROW_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_char_code,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [7:0]  o_glyph_code,
    output logic      [7:0]  o_cell_column,
    output logic      [15:0] o_cell_row,
    output logic      [3:0]  o_atlas_x,
    output logic      [3:0]  o_atlas_y,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    typedef enum logic {ST_IDLE, ST_TAB} t_state;

    t_state              r_state, n_state;
    logic [7:0]          r_columns;
    logic [3:0]          r_tab_width;
    logic [7:0]          r_prev, n_prev;
    logic [7:0]          r_line_cnt, n_line_cnt;
    logic [3:0]          r_tab_left, n_tab_left;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_glyph, n_glyph;
    logic [7:0]          r_col_out, n_col_out;
    logic [15:0]         r_row_out, n_row_out;

    tcl_pkg::t_cur_cmd   cmd;
    logic [7:0]          cur_col;
    logic [ROW_BITS-1:0] cur_row;
    logic [15:0]         cur_row16;
    logic                in_acc;
    logic                is_lf, is_cr, is_tab, is_space;
    logic [8:0]          cnt_next;

    tcl_cursor #(.ROW_BITS(ROW_BITS)) u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_columns (r_columns),
        .o_column  (cur_col),
        .o_row     (cur_row)
    );

    generate
        if (ROW_BITS >= 16) begin : g_row_trunc
            assign cur_row16 = cur_row[15:0];
        end else begin : g_row_ext
            assign cur_row16 = {{(16-ROW_BITS){1'b0}}, cur_row};
        end
    endgenerate

    assign o_in_stall = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign in_acc     = i_in_valid && !o_in_stall;

    assign is_lf    = (i_char_code == tcl_pkg::CH_LF);
    assign is_cr    = (i_char_code == tcl_pkg::CH_CR);
    assign is_tab   = (i_char_code == tcl_pkg::CH_TAB);
    assign is_space = (i_char_code == tcl_pkg::CH_SPACE);
    assign cnt_next = {1'b0, r_line_cnt} + 9'd1;

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_line_cnt  = r_line_cnt;
        n_tab_left  = r_tab_left;
        n_glyph     = r_glyph;
        n_col_out   = r_col_out;
        n_row_out   = r_row_out;
        n_out_valid = r_out_valid && i_out_stall;
        cmd         = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_prev = i_char_code;
                    if (is_lf || is_cr) begin
                        // CR after LF, or LF after CR, is absorbed
                        if (r_prev != (is_lf ? tcl_pkg::CH_CR : tcl_pkg::CH_LF)) begin
                            cmd.line_end = (r_line_cnt != 8'd0);
                            n_line_cnt   = 8'd0;
                        end
                    end else begin
                        n_line_cnt = (cnt_next >= {1'b0, r_columns}) ? 8'd0 : cnt_next[7:0];
                        if (is_tab) begin
                            cmd.step = (r_tab_width != 4'd0);
                            if (r_tab_width > 4'd1) begin
                                n_tab_left = r_tab_width - 4'd1;
                                n_state    = ST_TAB;
                            end
                        end else begin
                            cmd.step = 1'b1;
                            if (!is_space) begin
                                n_out_valid = 1'b1;
                                n_glyph     = i_char_code;
                                n_col_out   = cur_col;
                                n_row_out   = cur_row16;
                            end
                        end
                    end
                end
            end
            ST_TAB: begin
                cmd.step   = 1'b1;
                n_tab_left = r_tab_left - 4'd1;
                if (r_tab_left == 4'd1) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_columns   <= tcl_pkg::COLUMNS_RESET;
            r_tab_width <= tcl_pkg::TAB_WIDTH_RESET;
            r_prev      <= 8'd0;
            r_line_cnt  <= 8'd0;
            r_tab_left  <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_line_cnt  <= n_line_cnt;
            r_tab_left  <= n_tab_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tcl_pkg::CFG_COLUMNS:   r_columns   <= i_cfg_data;
                    tcl_pkg::CFG_TAB_WIDTH: r_tab_width <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_glyph   <= n_glyph;
        r_col_out <= n_col_out;
        r_row_out <= n_row_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_glyph_code  = r_glyph;
    assign o_cell_column = r_col_out;
    assign o_cell_row    = r_row_out;
    assign o_atlas_x     = r_glyph[3:0];
    assign o_atlas_y     = 4'hF - r_glyph[7:4];

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_cell_layout_top. The bench keeps its own copy
// of the cursor, line count and registers, predicts one placement for every
// byte it sends other than tab, space, LF and CR, and checks each placement
// beat in order. Stimulus is a directed opening, then text-like random streams
// under several column and tab settings, three idle/stall profiles, and a run
// of wide tabs at one cell per row that moves the row counter quickly.
// ----------------------------------------------------------------------------

typedef struct {
    logic [7:0]  glyph;
    logic [7:0]  column;
    logic [15:0] row;
    logic [3:0]  atlas_x;
    logic [3:0]  atlas_y;
} t_placement;

class layout_scoreboard;
    logic [7:0]  columns;
    logic [3:0]  tab_width;
    logic [7:0]  prev_char;
    logic [7:0]  cur_col;
    logic [15:0] cur_row;
    logic [7:0]  line_cnt;
    t_placement  pending[$];
    int          errors = 0;

    function void reset_state();
        columns   = tcl_pkg::COLUMNS_RESET;
        tab_width = tcl_pkg::TAB_WIDTH_RESET;
        prev_char = 8'd0;
        cur_col   = 8'd0;
        cur_row   = 16'd0;
        line_cnt  = 8'd0;
        pending.delete();
    endfunction

    function void write_reg(logic idx, logic [7:0] data);
        if (idx == tcl_pkg::CFG_COLUMNS) begin
            columns = data;
        end else begin
            tab_width = data[3:0];
        end
    endfunction

    function void next_row();
        cur_col = 8'd0;
        cur_row = cur_row + 16'd1;
    endfunction

    // single-cell advance; columns of zero wraps every time
    function void step_cell();
        if (int'(cur_col) + 1 >= int'(columns)) begin
            next_row();
        end else begin
            cur_col = cur_col + 8'd1;
        end
    endfunction

    function void note_char(logic [7:0] c);
        logic [7:0] prev;
        logic [7:0] partner;
        t_placement p;
        prev      = prev_char;
        prev_char = c;
        if (c == tcl_pkg::CH_LF || c == tcl_pkg::CH_CR) begin
            partner = (c == tcl_pkg::CH_LF) ? tcl_pkg::CH_CR : tcl_pkg::CH_LF;
            // second half of a CR/LF pair is absorbed
            if (prev != partner) begin
                if (line_cnt != 8'd0) begin
                    next_row();
                end
                line_cnt = 8'd0;
            end
            return;
        end
        if (c == tcl_pkg::CH_SPACE) begin
            step_cell();
        end else if (c == tcl_pkg::CH_TAB) begin
            for (int i = 0; i < int'(tab_width); i++) begin
                step_cell();
            end
        end else begin
            p.glyph   = c;
            p.column  = cur_col;
            p.row     = cur_row;
            p.atlas_x = c[3:0];
            p.atlas_y = 4'd15 - c[7:4];
            pending = {pending, p};
            step_cell();
        end
        line_cnt = (int'(line_cnt) + 1 >= int'(columns)) ? 8'd0 : line_cnt + 8'd1;
    endfunction

    task report_mismatch(string what);
        errors++;
        $display("%0t MISMATCH: %s", $realtime, what);
    endtask

    task compare_field(string name, int got, int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    task check_placement(logic [7:0] glyph, logic [7:0] column, logic [15:0] row,
                         logic [3:0] atlas_x, logic [3:0] atlas_y);
        t_placement want;
        if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected placement of glyph 0x%02h", glyph));
        end else begin
            want = pending.pop_front();
            compare_field("glyph_code", glyph, want.glyph);
            compare_field("cell_column", column, want.column);
            compare_field("cell_row", row, want.row);
            compare_field("atlas_x", atlas_x, want.atlas_x);
            compare_field("atlas_y", atlas_y, want.atlas_y);
        end
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 20;     // longer than a full-width tab
    localparam int PHASE_ITEMS   = 110;
    localparam int WRAP_TABS     = 60;     // 15 rows each

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  char_code = 8'd0;
    logic        out_stall = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = 8'd0;
    wire         in_stall;
    wire         out_valid;
    wire  [7:0]  glyph_code;
    wire  [7:0]  cell_column;
    wire  [15:0] cell_row;
    wire  [3:0]  atlas_x;
    wire  [3:0]  atlas_y;

    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    int          cycles = 0;

    layout_scoreboard sb = new();

    text_cell_layout_top DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_char_code   (char_code),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_glyph_code  (glyph_code),
        .o_cell_column (cell_column),
        .o_cell_row    (cell_row),
        .o_atlas_x     (atlas_x),
        .o_atlas_y     (atlas_y),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // everything observed at one edge is handled here, inputs first
    always @(posedge clk) begin
        if (!rst_n) begin
            sb.reset_state();
        end else begin
            if (cfg_we) begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall) begin
                sb.note_char(char_code);
            end
            if (out_valid && !out_stall) begin
                sb.check_placement(glyph_code, cell_column, cell_row, atlas_x, atlas_y);
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task send_char(logic [7:0] c);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    // wait for every placement, then let a pending tab finish
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_config(logic [7:0] cols, logic [3:0] tab);
        cfg_we    <= 1'b1;
        cfg_index <= tcl_pkg::CFG_COLUMNS;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_index <= tcl_pkg::CFG_TAB_WIDTH;
        cfg_data  <= {4'($urandom_range(15)), tab};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // text-like mix: mostly arbitrary bytes, plenty of whitespace and line ends
    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12) return tcl_pkg::CH_SPACE;
        if (r < 20) return tcl_pkg::CH_TAB;
        if (r < 30) return tcl_pkg::CH_LF;
        if (r < 40) return tcl_pkg::CH_CR;
        return 8'($urandom_range(255));
    endfunction

    initial begin
        logic [7:0] directed[$];
        int unsigned phase_cols[6];
        int unsigned phase_tab[6];
        logic [7:0] cols;
        logic [3:0] tab;

        phase_cols = '{1, 255, 0, 7, 3, 40};
        phase_tab  = '{0, 15, 3, 2, 9, 4};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening at reset settings
        directed = '{8'h48, 8'h00, 8'hFF, 8'h80, 8'h7F, tcl_pkg::CH_SPACE, 8'h61,
                     tcl_pkg::CH_TAB, 8'h62, tcl_pkg::CH_CR, tcl_pkg::CH_LF, 8'h63,
                     tcl_pkg::CH_LF, tcl_pkg::CH_CR, tcl_pkg::CH_LF, tcl_pkg::CH_LF,
                     tcl_pkg::CH_LF, tcl_pkg::CH_CR, tcl_pkg::CH_CR, 8'h64, 8'h0B,
                     8'h1F, 8'hA5};
        foreach (directed[k]) begin
            send_char(directed[k]);
        end
        drain();

        for (int s = 0; s < 3; s++) begin
            case (s)
                0: begin
                    in_idle_pct   = 23;
                    out_stall_pct = 65;
                end
                1: begin
                    in_idle_pct   = 65;
                    out_stall_pct = 23;
                end
                default: begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
            endcase
            for (int p = 0; p < 6; p++) begin
                if (s == 0) begin
                    cols = 8'(phase_cols[p]);
                    tab  = 4'(phase_tab[p]);
                end else begin
                    cols = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                    : 8'($urandom_range(1, 20));
                    tab  = 4'($urandom_range(15));
                end
                // lines are left open on purpose so the column limit changes mid-line
                write_config(cols, tab);
                repeat (PHASE_ITEMS) send_char(pick_char());
                drain();
            end
        end

        // one cell per row and wide tabs run the row counter up fast
        write_config(8'd1, 4'd15);
        repeat (WRAP_TABS) send_char(tcl_pkg::CH_TAB);
        repeat (30) send_char(8'($urandom_range(33, 255)));
        drain();

        if (sb.pending.size() != 0) begin
            sb.report_mismatch($sformatf("%0d placements never arrived", sb.pending.size()));
        end
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
